FILE: design/sttl_pkg.sv
package sttl_pkg;

    localparam int FREQ_BITS_DEF = 24;
    localparam int TEMP_BITS_DEF = 8;

    localparam int LIMIT_W = 7;
    localparam int PCT_W   = 7;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int CLS_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] TEMP_LIMIT_RST = 7'd95;
    localparam logic [31:0]        HW_MIN_RST     = 32'd800000;
    localparam logic [31:0]        HW_MAX_RST     = 32'd3000000;

    // threshold percentages of the failsafe temperature
    localparam logic [PCT_W-1:0] THR_PCT_STRONG = 7'd93;
    localparam logic [PCT_W-1:0] THR_PCT_MEDIUM = 7'd86;
    localparam logic [PCT_W-1:0] THR_PCT_LIGHT  = 7'd79;
    localparam logic [PCT_W-1:0] PCT_DEN        = 7'd100;

    // step points as percent of the range above the minimum
    localparam logic [PCT_W-1:0] STEP_PCT_LIGHT  = 7'd85;
    localparam logic [PCT_W-1:0] STEP_PCT_MEDIUM = 7'd65;
    localparam logic [PCT_W-1:0] STEP_PCT_STRONG = 7'd40;
    localparam logic [PCT_W-1:0] HYST_PCT        = 7'd10;

    // divide by 100 through a reciprocal, exact for inputs below 2^27
    localparam int SPLIT_W     = 20;
    localparam int DIV_IN_W    = PCT_W + SPLIT_W;
    localparam int DIV_OUT_W   = 21;
    localparam int DIV_SHIFT   = 34;
    localparam int DIV_MAGIC_W = 28;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
        DIV_MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

    typedef enum logic [2:0] {
        LVL_FULL     = 3'd0,
        LVL_LIGHT    = 3'd1,
        LVL_MEDIUM   = 3'd2,
        LVL_STRONG   = 3'd3,
        LVL_FAILSAFE = 3'd4
    } t_level;

    typedef enum logic [2:0] {
        REG_TEMP_LIMIT  = 3'd0,
        REG_FLOOR_FREQ  = 3'd1,
        REG_CAP_FREQ    = 3'd2,
        REG_HW_MIN_FREQ = 3'd3,
        REG_HW_MAX_FREQ = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_level level;
        logic   below_limit;
    } t_cls;

    typedef struct packed {
        t_level level;
        logic   below_limit;
        logic   span_neg;
    } t_tag;

    function automatic logic [DIV_OUT_W-1:0] div100(input logic [DIV_IN_W-1:0] x);
        logic [DIV_IN_W+DIV_MAGIC_W-1:0] prod;
        prod = {{DIV_MAGIC_W{1'b0}}, x} * {{DIV_IN_W{1'b0}}, DIV_MAGIC};
        return prod[DIV_SHIFT +: DIV_OUT_W];
    endfunction

endpackage

FILE: design/sttl_fifo.sv
module sttl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: design/sttl_front.sv
module sttl_front #(
    parameter int TEMP_BITS = sttl_pkg::TEMP_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [TEMP_BITS-1:0]         i_temp_c,
    input  logic [sttl_pkg::LIMIT_W-1:0] i_temp_limit,
    output logic                         o_cls_push,
    output sttl_pkg::t_cls               o_cls,
    input  logic                         i_cls_full
);

    localparam int CW = TEMP_BITS + sttl_pkg::PCT_W;

    logic                 r_valid;
    logic [TEMP_BITS-1:0] r_temp;
    logic [CW-1:0]        lim_ext;
    logic [CW-1:0]        rhs;
    logic                 ge_lim;
    logic                 ge_strong;
    logic                 ge_medium;
    logic                 ge_light;

    assign o_cls_push = r_valid && !i_cls_full;
    assign o_full     = r_valid && i_cls_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !o_full) begin
            r_valid <= 1'b1;
        end else if (o_cls_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_temp <= i_temp_c;
        end
    end

    // t >= (lim*p)/100 holds exactly when lim*p <= 100*t + 99
    always_comb begin
        lim_ext   = CW'(i_temp_limit);
        rhs       = CW'(r_temp) * CW'(sttl_pkg::PCT_DEN) + CW'(sttl_pkg::PCT_DEN - 1'b1);
        ge_lim    = CW'(r_temp) >= lim_ext;
        ge_strong = (lim_ext * CW'(sttl_pkg::THR_PCT_STRONG)) <= rhs;
        ge_medium = (lim_ext * CW'(sttl_pkg::THR_PCT_MEDIUM)) <= rhs;
        ge_light  = (lim_ext * CW'(sttl_pkg::THR_PCT_LIGHT)) <= rhs;
        o_cls.below_limit = !ge_lim;
        priority if (ge_lim) begin
            o_cls.level = sttl_pkg::LVL_FAILSAFE;
        end else if (ge_strong) begin
            o_cls.level = sttl_pkg::LVL_STRONG;
        end else if (ge_medium) begin
            o_cls.level = sttl_pkg::LVL_MEDIUM;
        end else if (ge_light) begin
            o_cls.level = sttl_pkg::LVL_LIGHT;
        end else begin
            o_cls.level = sttl_pkg::LVL_FULL;
        end
    end

endmodule

FILE: design/sttl_back.sv
module sttl_back #(
    parameter int FREQ_BITS = sttl_pkg::FREQ_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sttl_pkg::t_cls       i_cls,
    input  logic                 i_cls_empty,
    output logic                 o_cls_pop,
    input  logic [FREQ_BITS-1:0] i_hw_min,
    input  logic [FREQ_BITS-1:0] i_hw_max,
    input  logic [FREQ_BITS-1:0] i_cap,
    input  logic [FREQ_BITS-1:0] i_floor,
    output logic                 o_res_push,
    output logic [FREQ_BITS-1:0] o_freq_limit,
    output logic                 o_apply_change,
    output sttl_pkg::t_level     o_level,
    input  logic                 i_res_full
);

    localparam int FB    = FREQ_BITS;
    localparam int PW    = FB + sttl_pkg::PCT_W;
    localparam int PHW   = PW - sttl_pkg::SPLIT_W;
    localparam int SW    = sttl_pkg::SPLIT_W;
    localparam int RW    = PHW + sttl_pkg::PCT_W;
    localparam int NL    = 2;
    localparam int NST   = 6;

    logic                en;
    logic [NST-1:0]      r_v;
    sttl_pkg::t_tag      r_tag [NST];
    logic [FB-1:0]       r_top [NST-1];

    logic [FB-1:0]       s0_top;
    logic                s0_neg;
    logic [FB-1:0]       s0_mag;
    logic [FB-1:0]       r_mag;

    logic [sttl_pkg::PCT_W-1:0] s1_pct;
    logic [PW-1:0]       r_prod [NL];

    logic [sttl_pkg::DIV_OUT_W-1:0] s2_dq [NL];
    logic [PHW-1:0]      r_qh2 [NL];
    logic [PHW-1:0]      r_ph2 [NL];
    logic [SW-1:0]       r_pl2 [NL];

    logic [RW-1:0]       s3_rem [NL];
    logic [sttl_pkg::PCT_W-1:0] r_rh3 [NL];
    logic [PHW-1:0]      r_qh3 [NL];
    logic [SW-1:0]       r_pl3 [NL];

    logic [sttl_pkg::DIV_OUT_W-1:0] s4_dq [NL];
    logic [PW-1:0]       s4_q [NL];
    logic [FB-1:0]       r_q4 [NL];

    logic [FB-1:0]       s5_f;
    logic [FB-1:0]       r_f;
    logic [FB-1:0]       r_b10;

    logic [FB-1:0]       r_applied;
    logic [FB-1:0]       diff;
    logic                apply;

    // the whole line moves together unless a finished result is blocked
    assign en         = !r_v[NST-1] || !i_res_full;
    assign o_cls_pop  = en && !i_cls_empty;
    assign o_res_push = r_v[NST-1] && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], o_cls_pop};
        end
    end

    // stage 0: top frequency and magnitude of the range
    always_comb begin
        s0_top = ((i_cap != '0) && (i_cap < i_hw_max)) ? i_cap : i_hw_max;
        s0_neg = s0_top < i_hw_min;
        s0_mag = s0_neg ? (i_hw_min - s0_top) : (s0_top - i_hw_min);
    end

    // stage 1: scale by the level percent and by the hysteresis percent
    always_comb begin
        unique case (r_tag[0].level)
            sttl_pkg::LVL_LIGHT:  s1_pct = sttl_pkg::STEP_PCT_LIGHT;
            sttl_pkg::LVL_MEDIUM: s1_pct = sttl_pkg::STEP_PCT_MEDIUM;
            sttl_pkg::LVL_STRONG: s1_pct = sttl_pkg::STEP_PCT_STRONG;
            default:              s1_pct = '0;
        endcase
    end

    // stages 2 to 4: long division by 100 in two chunks
    always_comb begin
        for (int j = 0; j < NL; j++) begin
            s2_dq[j]  = sttl_pkg::div100(
                sttl_pkg::DIV_IN_W'(r_prod[j][PW-1:SW]));
            s3_rem[j] = RW'(r_ph2[j]) - RW'(r_qh2[j]) * RW'(sttl_pkg::PCT_DEN);
            s4_dq[j]  = sttl_pkg::div100({r_rh3[j], r_pl3[j]});
            s4_q[j]   = {r_qh3[j], s4_dq[j][SW-1:0]};
        end
    end

    // stage 5: pick the step point and apply the floor
    always_comb begin
        unique case (r_tag[4].level)
            sttl_pkg::LVL_FULL:     s5_f = r_top[4];
            sttl_pkg::LVL_FAILSAFE: s5_f = i_hw_min;
            default: begin
                s5_f = r_tag[4].span_neg ? (i_hw_min - r_q4[0]) : (i_hw_min + r_q4[0]);
            end
        endcase
        if ((i_floor != '0) && r_tag[4].below_limit && (s5_f < i_floor)) begin
            s5_f = i_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag    <= s0_mag;
            r_top[0] <= s0_top;
            r_tag[0] <= '{level: i_cls.level, below_limit: i_cls.below_limit,
                          span_neg: s0_neg};
            for (int k = 1; k < NST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 1; k < NST - 1; k++) begin
                r_top[k] <= r_top[k-1];
            end
            r_prod[0] <= PW'(r_mag) * PW'(s1_pct);
            r_prod[1] <= PW'(r_mag) * PW'(sttl_pkg::HYST_PCT);
            for (int j = 0; j < NL; j++) begin
                r_qh2[j] <= s2_dq[j][PHW-1:0];
                r_ph2[j] <= r_prod[j][PW-1:SW];
                r_pl2[j] <= r_prod[j][SW-1:0];
                r_rh3[j] <= s3_rem[j][sttl_pkg::PCT_W-1:0];
                r_qh3[j] <= r_qh2[j];
                r_pl3[j] <= r_pl2[j];
                r_q4[j]  <= s4_q[j][FB-1:0];
            end
            r_f   <= s5_f;
            r_b10 <= r_q4[1];
        end
    end

    // hysteresis: change only if step > range/10, unless top < min
    always_comb begin
        diff = (r_f >= r_applied) ? (r_f - r_applied) : (r_applied - r_f);
        if (r_tag[NST-1].span_neg) begin
            apply = (r_b10 != '0) || (diff != '0);
        end else begin
            apply = diff > r_b10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_applied <= '0;
        end else if (o_res_push && apply) begin
            r_applied <= r_f;
        end
    end

    assign o_freq_limit   = r_f;
    assign o_apply_change = apply;
    assign o_level        = r_tag[NST-1].level;

endmodule

FILE: design/stepped_thermal_throttle_top.sv
// Channel      | Handshake                         | Payload
// -------------+-----------------------------------+------------------------------------
// sample in    | push / full                       | i_temp_c
// result out   | empty / pop                       | o_freq_limit, o_apply_change,
//              |                                   | o_throttle_level
// config       | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// One sample per cycle sustained while no result is blocked; a result passes the input register,
// classify queue, six back stages and output queue in that order.
// The six-stage back line holds the two-chunk divide by 100.
// Synchronous active-low reset clears control state and the kept frequency; no sweep.
// A blocked result stalls the back line, then the classify queue fills and full rises.
module stepped_thermal_throttle_top #(
    parameter int FREQ_BITS = sttl_pkg::FREQ_BITS_DEF,
    parameter int TEMP_BITS = sttl_pkg::TEMP_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [TEMP_BITS-1:0]        i_temp_c,
    output logic                        empty,
    input  logic                        pop,
    output logic [FREQ_BITS-1:0]        o_freq_limit,
    output logic                        o_apply_change,
    output logic [2:0]                  o_throttle_level,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sttl_pkg::ADDR_W-1:0] paddr,
    input  logic [sttl_pkg::DATA_W-1:0] pwdata,
    output logic [sttl_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int RES_W = FREQ_BITS + 1 + 3;

    // configuration registers
    logic [sttl_pkg::LIMIT_W-1:0] r_temp_limit;
    logic [FREQ_BITS-1:0]         r_floor;
    logic [FREQ_BITS-1:0]         r_cap;
    logic [FREQ_BITS-1:0]         r_hw_min;
    logic [FREQ_BITS-1:0]         r_hw_max;
    sttl_pkg::t_reg_idx           reg_idx;
    logic                         cfg_wr;

    // front to back
    logic                         cls_push;
    logic                         cls_full;
    logic                         cls_pop;
    logic                         cls_empty;
    sttl_pkg::t_cls               cls_in;
    sttl_pkg::t_cls               cls_out;

    // back to output queue
    logic                         res_push;
    logic                         res_full;
    logic [FREQ_BITS-1:0]         res_freq;
    logic                         res_apply;
    sttl_pkg::t_level             res_level;
    logic [RES_W-1:0]             res_head;

    assign pready  = 1'b1;
    assign reg_idx = sttl_pkg::t_reg_idx'(paddr[sttl_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // write a register on the access cycle; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limit <= sttl_pkg::TEMP_LIMIT_RST;
            r_floor      <= '0;
            r_cap        <= '0;
            r_hw_min     <= FREQ_BITS'(sttl_pkg::HW_MIN_RST);
            r_hw_max     <= FREQ_BITS'(sttl_pkg::HW_MAX_RST);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sttl_pkg::REG_TEMP_LIMIT:  r_temp_limit <= pwdata[sttl_pkg::LIMIT_W-1:0];
                sttl_pkg::REG_FLOOR_FREQ:  r_floor      <= pwdata[FREQ_BITS-1:0];
                sttl_pkg::REG_CAP_FREQ:    r_cap        <= pwdata[FREQ_BITS-1:0];
                sttl_pkg::REG_HW_MIN_FREQ: r_hw_min     <= pwdata[FREQ_BITS-1:0];
                sttl_pkg::REG_HW_MAX_FREQ: r_hw_max     <= pwdata[FREQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (reg_idx)
            sttl_pkg::REG_TEMP_LIMIT:  prdata = sttl_pkg::DATA_W'(r_temp_limit);
            sttl_pkg::REG_FLOOR_FREQ:  prdata = sttl_pkg::DATA_W'(r_floor);
            sttl_pkg::REG_CAP_FREQ:    prdata = sttl_pkg::DATA_W'(r_cap);
            sttl_pkg::REG_HW_MIN_FREQ: prdata = sttl_pkg::DATA_W'(r_hw_min);
            sttl_pkg::REG_HW_MAX_FREQ: prdata = sttl_pkg::DATA_W'(r_hw_max);
            default:                   prdata = '0;
        endcase
    end

    // front: take a sample and classify it against the thresholds
    sttl_front #(
        .TEMP_BITS (TEMP_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_temp_c     (i_temp_c),
        .i_temp_limit (r_temp_limit),
        .o_cls_push   (cls_push),
        .o_cls        (cls_in),
        .i_cls_full   (cls_full)
    );

    // short queue that decouples classification from the frequency math
    sttl_fifo #(
        .WIDTH ($bits(sttl_pkg::t_cls)),
        .DEPTH (sttl_pkg::CLS_Q_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cls_push),
        .i_data  (cls_in),
        .o_full  (cls_full),
        .i_pop   (cls_pop),
        .o_data  (cls_out),
        .o_empty (cls_empty)
    );

    // back: step point, floor and hysteresis
    sttl_back #(
        .FREQ_BITS (FREQ_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cls          (cls_out),
        .i_cls_empty    (cls_empty),
        .o_cls_pop      (cls_pop),
        .i_hw_min       (r_hw_min),
        .i_hw_max       (r_hw_max),
        .i_cap          (r_cap),
        .i_floor        (r_floor),
        .o_res_push     (res_push),
        .o_freq_limit   (res_freq),
        .o_apply_change (res_apply),
        .o_level        (res_level),
        .i_res_full     (res_full)
    );

    // output queue: holds finished results while the consumer stalls
    sttl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (sttl_pkg::OUT_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_freq, res_apply, res_level}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_freq_limit     = res_head[RES_W-1 -: FREQ_BITS];
    assign o_apply_change   = res_head[3];
    assign o_throttle_level = res_head[2:0];

endmodule

FILE: design/sttl_checker.sv
module sttl_checker #(
    parameter int FREQ_BITS = sttl_pkg::FREQ_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [FREQ_BITS-1:0] o_freq_limit,
    input logic                 o_apply_change,
    input logic [2:0]           o_throttle_level
);

    // reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a new sample
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // a waiting result holds until it is taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_freq_limit)
            && $stable(o_apply_change) && $stable(o_throttle_level)))
        else $error("waiting result changed before transfer");

endmodule

bind stepped_thermal_throttle_top sttl_checker #(
    .FREQ_BITS (FREQ_BITS)
) u_sttl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_freq_limit     (o_freq_limit),
    .o_apply_change   (o_apply_change),
    .o_throttle_level (o_throttle_level)
);
